// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_REAR   = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } cdq_stat_t;

endpackage

// File: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: takes an action, runs it through the datapath, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // The result waits here until the output register is free.
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Pointers, entry count, word store and output register of the queue.
// ----------------------------------------------------------------------------
module cdq_datapath #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdq_pkg::cdq_cmd_t             cmd,
    output cdq_pkg::cdq_stat_t            stat,
    input  cdq_pkg::action_t              in_action,
    input  logic [cdq_pkg::VALUE_W-1:0]   in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cdq_pkg::VALUE_W-1:0]   out_value,
    output cdq_pkg::status_t              out_status,
    output logic [cdq_pkg::COUNT_W-1:0]   out_count
);
    import cdq_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [VALUE_W-1:0] mem [DEPTH];

    action_t            act_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    status_t            res_status_reg, res_status_next;
    logic               res_pop_reg;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               mem_we, mem_re;
    logic [IW-1:0]      wr_addr, rd_addr;
    logic               q_empty, q_full, is_pop;
    logic [CW+COUNT_W-1:0] count_ext;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == FULL_CNT);
    assign is_pop  = act_reg[1];
    assign rd_addr = (act_reg == ACT_POP_REAR) ? tail_reg : head_reg;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_status_next = ST_DONE;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        wr_addr         = '0;
        if (!is_pop) begin
            if (q_full) begin
                res_status_next = ST_FULL;
            end else begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                if (q_empty) begin
                    // First word always lands at the bottom of the store.
                    head_next = '0;
                    tail_next = '0;
                    wr_addr   = '0;
                end else if (act_reg == ACT_PUSH_REAR) begin
                    tail_next = idx_inc(tail_reg);
                    wr_addr   = tail_next;
                end else begin
                    head_next = idx_dec(head_reg);
                    wr_addr   = head_next;
                end
            end
        end else begin
            if (q_empty) begin
                res_status_next = ST_EMPTY;
            end else begin
                mem_re     = 1'b1;
                count_next = count_reg - 1'b1;
                if (head_reg == tail_reg) begin
                    head_next = '0;
                    tail_next = '0;
                end else if (act_reg == ACT_POP_REAR) begin
                    tail_next = idx_dec(tail_reg);
                end else begin
                    head_next = idx_inc(head_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.exec && mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= in_action;
            value_reg <= in_value;
        end
        if (cmd.exec) begin
            res_status_reg <= res_status_next;
            res_pop_reg    <= is_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_value_reg  <= (res_pop_reg && res_status_reg == ST_DONE) ?
                              rd_data_reg : '0;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_status    = out_status_reg;
    assign out_count     = out_count_reg;

endmodule

// File: rtl/circular_double_ended_queue.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue of 32-bit words held in a circular store of DEPTH words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one action per transfer: s_tuser holds the
//   action (push rear, push front, pop rear, pop front) and s_tdata the word
//   to push. Each action yields exactly one transfer on the master channel:
//   m_tdata carries the popped word (zero unless a pop succeeded) and the
//   entry count after the action, m_tuser the status (done, full, empty).
//   A rejected push or pop leaves the queue unchanged.
//   One action is in flight at a time: the sequencer captures the action,
//   executes it (pointer update together with the registered read of the
//   single store port), then loads the result into the output register,
//   and takes no new action before it has loaded the last result.
//   The output register lets a new action be accepted while the previous
//   result still waits; if the receiver stalls, the sequencer holds the next
//   result internally and s_tready stays low until it can be loaded.
//   Reset empties the queue and drops any pending result; store contents are
//   not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_double_ended_queue #(
    parameter int unsigned DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] pop_value, [39:32] entry_count
    output logic [1:0]  m_tuser    // [1:0] status
);
    import cdq_pkg::*;

    cdq_cmd_t           cmd;
    cdq_stat_t          stat;
    logic [VALUE_W-1:0] out_value;
    status_t            out_status;
    logic [COUNT_W-1:0] out_count;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (action_t'(s_tuser)),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {out_count, out_value};
    assign m_tuser = out_status;

    localparam logic [COUNT_W+31:0] DEPTH_EXT = (COUNT_W + 32)'(DEPTH);

    // Only one action is in flight: an accepted transfer blocks the next.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second action accepted while one is in flight");

    // A pop rejected as empty reports an empty queue and no word.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata == '0))
        else $error("empty status with nonzero count or word");

    // A push rejected as full reports a full queue and no word.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |->
        (m_tdata[39:32] == DEPTH_EXT[COUNT_W-1:0] && m_tdata[31:0] == '0))
        else $error("full status with wrong count or nonzero word");

endmodule
